### hdl/cpx_pkg.sv
// Package for the cpio newc file extractor.
// Holds phase and command codes, header offsets and small decode helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpx_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NAME,
    PH_NAME_PAD,
    PH_DATA,
    PH_DATA_PAD
  } phase_t;

  // Input commands
  localparam logic [1:0] CMD_NAME_CHAR  = 2'd0;
  localparam logic [1:0] CMD_ARCHIVE    = 2'd1;
  localparam logic [1:0] CMD_NEW_SEARCH = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_DATA      = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // Header layout (byte offsets within the 110-byte newc header)
  localparam logic [31:0] HDR_LAST    = 32'd109;
  localparam logic [31:0] FSIZE_FIRST = 32'd54;
  localparam logic [31:0] FSIZE_END   = 32'd62;
  localparam logic [31:0] NSIZE_FIRST = 32'd94;
  localparam logic [31:0] NSIZE_END   = 32'd102;
  localparam logic [31:0] TRAILER_LEN = 32'd10;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  function automatic logic [7:0] trailer_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0: c = 8'h54;  // T
      4'd1: c = 8'h52;  // R
      4'd2: c = 8'h41;  // A
      4'd3: c = 8'h49;  // I
      4'd4: c = 8'h4C;  // L
      4'd5: c = 8'h45;  // E
      4'd6: c = 8'h52;  // R
      default: c = 8'h21;  // !
    endcase
    return c;
  endfunction

  // Letters A-F (and a-f, by the low nibble) map to 10..15, the rest to c - '0'
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c >= CHAR_A) begin
      v = c - CHAR_A + 8'd10;
    end else begin
      v = c - CHAR_ZERO;
    end
    return v[3:0];
  endfunction

  // Pad after header plus name; the header length is 2 modulo 4
  function automatic logic [1:0] name_pad(input logic [31:0] ns);
    return 2'd0 - (ns[1:0] + 2'd2);
  endfunction

  function automatic logic [1:0] data_pad(input logic [31:0] fs);
    return 2'd0 - fs[1:0];
  endfunction

  function automatic phase_t after_data(input logic [31:0] fs);
    return (data_pad(fs) != 2'd0) ? PH_DATA_PAD : PH_HEADER;
  endfunction

  function automatic phase_t after_name(input logic [31:0] ns, input logic [31:0] fs);
    phase_t p;
    if (name_pad(ns) != 2'd0) begin
      p = PH_NAME_PAD;
    end else if (fs != 32'd0) begin
      p = PH_DATA;
    end else begin
      p = after_data(fs);
    end
    return p;
  endfunction

endpackage

`default_nettype wire

### hdl/cpx_if.sv
// Valid/ready channel interfaces for the cpio newc file extractor.
// One interface for the command channel, one for the result channel.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface cpx_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface cpx_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] data_out;
  logic       last;

  modport source (output valid, output status, output data_out, output last, input ready);
  modport sink (input valid, input status, input data_out, input last, output ready);
endinterface

`default_nettype wire

### hdl/cpx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read during a write to the same address returns the old contents.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cpx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### hdl/cpio_newc_file_extractor_core.sv
// cpio newc file extractor, top level.
// Depends on cpx_pkg, the cpx_in_if / cpx_out_if interfaces and cpx_ram.
//
// in_ch carries commands: CMD_NAME_CHAR loads one target name character (CR
// and LF are dropped), CMD_NEW_SEARCH clears the name and the parser, and
// CMD_ARCHIVE feeds one byte of a newc archive. An item is taken at a clock
// edge where valid and ready are both high.
// out_ch carries results: each data byte of the first entry whose name equals
// the target (ST_DATA, last on the final byte), a single ST_EMPTY item for a
// matching empty file, or a single ST_NOT_FOUND item at the trailer. After
// that, drop archive bytes until the next new-search command.
// Timing: one item per cycle, sustained while no result stalls; a result is
// valid on out_ch the cycle after the item that causes it. The target name sits
// in a RAM with a registered read: fetch the entry for the next name byte ahead
// and bypass a name character written to that entry in the same cycle.
// Reset and stalls: rst (synchronous) empties the name and clears the parser
// and the result valid flag; the name RAM is not cleared, as only entries below
// the name length are compared. A stalled result blocks in_ch, which is ready
// again in the cycle that result is taken.
`timescale 1ns / 1ps
`default_nettype none

module cpio_newc_file_extractor_core
  import cpx_pkg::*;
#(
  parameter int NAME_MAX = 256
) (
  input wire logic  clk,
  input wire logic  rst,
  cpx_in_if.sink    in_ch,
  cpx_out_if.source out_ch
);

  localparam int AW  = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
  localparam int TLW = $clog2(NAME_MAX + 1);

  // Parser and name state
  logic [TLW-1:0] target_length,       target_length_next;
  logic           name_too_long,       name_too_long_next;
  phase_t         phase,               phase_next;
  logic [31:0]    byte_count,          byte_count_next;
  logic [31:0]    entry_name_size,     entry_name_size_next;
  logic [31:0]    entry_file_size,     entry_file_size_next;
  logic           name_still_equal,    name_still_equal_next;
  logic           trailer_still_equal, trailer_still_equal_next;
  logic           entry_selected,      entry_selected_next;
  logic           search_finished,     search_finished_next;

  // Result register
  logic           out_valid;
  logic [1:0]     out_status;
  logic [7:0]     out_data;
  logic           out_last;

  // Name RAM access
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  logic [7:0]     ram_rdata;
  logic           byp_hit;
  logic [7:0]     byp_data;
  logic [7:0]     name_char;

  // Combinational results of this item
  logic           in_accept;
  logic           emit;
  logic [1:0]     emit_status;
  logic [7:0]     emit_data;
  logic           emit_last;
  logic           fin_name;
  logic [31:0]    bc_inc;
  logic           hit;

  // Accept whenever the result register is empty or being drained
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign bc_inc      = byte_count + 32'd1;

  assign wr_addr   = target_length[AW-1:0];
  assign rd_addr   = byte_count_next[AW-1:0];
  assign name_char = byp_hit ? byp_data : ram_rdata;

  cpx_ram #(
    .WIDTH (8),
    .DEPTH (NAME_MAX)
  ) u_name_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_ch.data_byte),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    target_length_next       = target_length;
    name_too_long_next       = name_too_long;
    phase_next               = phase;
    byte_count_next          = byte_count;
    entry_name_size_next     = entry_name_size;
    entry_file_size_next     = entry_file_size;
    name_still_equal_next    = name_still_equal;
    trailer_still_equal_next = trailer_still_equal;
    entry_selected_next      = entry_selected;
    search_finished_next     = search_finished;
    emit        = 1'b0;
    emit_status = ST_DATA;
    emit_data   = 8'd0;
    emit_last   = 1'b0;
    wr_en       = 1'b0;
    fin_name    = 1'b0;
    hit         = 1'b0;

    if (in_accept) begin
      case (in_ch.cmd)
        CMD_NAME_CHAR: begin
          // Drop line terminators; flag overflow and drop the character
          if (in_ch.data_byte != CHAR_CR && in_ch.data_byte != CHAR_LF) begin
            if (target_length < TLW'(NAME_MAX)) begin
              wr_en              = 1'b1;
              target_length_next = target_length + 1'b1;
            end else begin
              name_too_long_next = 1'b1;
            end
          end
        end
        CMD_ARCHIVE: begin
          if (!search_finished) begin
            case (phase)
              PH_HEADER: begin
                if (byte_count >= FSIZE_FIRST && byte_count < FSIZE_END) begin
                  entry_file_size_next = {entry_file_size[27:0],
                                          hex_nibble(in_ch.data_byte)};
                end
                if (byte_count >= NSIZE_FIRST && byte_count < NSIZE_END) begin
                  entry_name_size_next = {entry_name_size[27:0],
                                          hex_nibble(in_ch.data_byte)};
                end
                if (byte_count >= HDR_LAST) begin
                  phase_next               = PH_NAME;
                  byte_count_next          = 32'd0;
                  name_still_equal_next    = 1'b1;
                  trailer_still_equal_next = 1'b1;
                  // An empty name is decided on the last header byte
                  fin_name = (entry_name_size == 32'd0);
                end else begin
                  byte_count_next = bc_inc;
                end
              end
              PH_NAME: begin
                if (byte_count < 32'(target_length)) begin
                  if (name_char != in_ch.data_byte) name_still_equal_next = 1'b0;
                end else if (byte_count == 32'(target_length)) begin
                  if (in_ch.data_byte != 8'd0) name_still_equal_next = 1'b0;
                end
                if (byte_count < TRAILER_LEN) begin
                  if (trailer_char(byte_count[3:0]) != in_ch.data_byte) begin
                    trailer_still_equal_next = 1'b0;
                  end
                end else if (byte_count == TRAILER_LEN) begin
                  if (in_ch.data_byte != 8'd0) trailer_still_equal_next = 1'b0;
                end
                if (bc_inc >= entry_name_size) begin
                  fin_name = 1'b1;
                end else begin
                  byte_count_next = bc_inc;
                end
              end
              PH_NAME_PAD: begin
                if (bc_inc >= 32'(name_pad(entry_name_size))) begin
                  phase_next      = (entry_file_size != 32'd0) ? PH_DATA
                                                               : after_data(entry_file_size);
                  byte_count_next = 32'd0;
                end else begin
                  byte_count_next = bc_inc;
                end
              end
              PH_DATA: begin
                if (entry_selected) begin
                  emit      = 1'b1;
                  emit_data = in_ch.data_byte;
                  emit_last = (bc_inc >= entry_file_size);
                  if (emit_last) begin
                    search_finished_next = 1'b1;
                  end else begin
                    byte_count_next = bc_inc;
                  end
                end else if (bc_inc >= entry_file_size) begin
                  phase_next      = after_data(entry_file_size);
                  byte_count_next = 32'd0;
                end else begin
                  byte_count_next = bc_inc;
                end
              end
              PH_DATA_PAD: begin
                if (bc_inc >= 32'(data_pad(entry_file_size))) begin
                  phase_next      = PH_HEADER;
                  byte_count_next = 32'd0;
                end else begin
                  byte_count_next = bc_inc;
                end
              end
              default: begin
                phase_next      = PH_HEADER;
                byte_count_next = 32'd0;
              end
            endcase
          end
        end
        CMD_NEW_SEARCH: begin
          target_length_next       = '0;
          name_too_long_next       = 1'b0;
          phase_next               = PH_HEADER;
          byte_count_next          = 32'd0;
          entry_name_size_next     = 32'd0;
          entry_file_size_next     = 32'd0;
          name_still_equal_next    = 1'b1;
          trailer_still_equal_next = 1'b1;
          entry_selected_next      = 1'b0;
          search_finished_next     = 1'b0;
        end
        default: begin
        end
      endcase
    end

    // Name region done: trailer first, then the target
    if (fin_name) begin
      hit = name_still_equal_next && !name_too_long &&
            (entry_name_size > 32'(target_length));
      if (trailer_still_equal_next && entry_name_size > TRAILER_LEN) begin
        search_finished_next = 1'b1;
        emit        = 1'b1;
        emit_status = ST_NOT_FOUND;
        emit_last   = 1'b1;
      end else if (hit && entry_file_size == 32'd0) begin
        entry_selected_next  = 1'b1;
        search_finished_next = 1'b1;
        emit        = 1'b1;
        emit_status = ST_EMPTY;
        emit_last   = 1'b1;
      end else begin
        entry_selected_next = entry_selected || hit;
        phase_next          = after_name(entry_name_size, entry_file_size);
        byte_count_next     = 32'd0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      target_length       <= '0;
      name_too_long       <= 1'b0;
      phase               <= PH_HEADER;
      byte_count          <= 32'd0;
      entry_name_size     <= 32'd0;
      entry_file_size     <= 32'd0;
      name_still_equal    <= 1'b1;
      trailer_still_equal <= 1'b1;
      entry_selected      <= 1'b0;
      search_finished     <= 1'b0;
      out_valid           <= 1'b0;
      byp_hit             <= 1'b0;
    end else begin
      target_length       <= target_length_next;
      name_too_long       <= name_too_long_next;
      phase               <= phase_next;
      byte_count          <= byte_count_next;
      entry_name_size     <= entry_name_size_next;
      entry_file_size     <= entry_file_size_next;
      name_still_equal    <= name_still_equal_next;
      trailer_still_equal <= trailer_still_equal_next;
      entry_selected      <= entry_selected_next;
      search_finished     <= search_finished_next;
      // Forward a name character written to the entry being fetched
      byp_hit             <= wr_en && (wr_addr == rd_addr);
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    byp_data <= in_ch.data_byte;
    if (emit) begin
      out_status <= emit_status;
      out_data   <= emit_data;
      out_last   <= emit_last;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.status   = out_status;
  assign out_ch.data_out = out_data;
  assign out_ch.last     = out_last;

endmodule

`default_nettype wire

### hdl/cpx_checker.sv
// Port-level checker for the cpio newc file extractor, with its bind.
// Depends on cpx_pkg and the top level cpio_newc_file_extractor_core.
`timescale 1ns / 1ps
`default_nettype none

module cpx_checker
  import cpx_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status,
  input wire logic [7:0] out_data,
  input wire logic       out_last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_data))
    else $error("result changed while stalled");

  // Block new items while a result is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("item accepted over a stalled result");

  a_status_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_DATA |-> out_data == 8'd0 && out_last)
    else $error("terminal status without last or with data");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind cpio_newc_file_extractor_core cpx_checker u_cpx_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_data   (out_ch.data_out),
  .out_last   (out_ch.last)
);

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the cpio newc file extractor core.
// Depends on cpx_pkg, the cpx_in_if / cpx_out_if interfaces and the core RTL.
// Streams archives and target names, predicts every result, checks in order.
`timescale 1ns / 1ps

module testbench;
  import cpx_pkg::*;

  localparam int NAME_MAX = 256;
  localparam int HDR_BYTES = 110;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int LONG_HOLD = 300;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [79:0] TRAILER_TEXT = "TRAILER!!!";

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data;
    logic       last;
  } extract_result_t;

  // Tracks the extractor state and the results it owes, in arrival order.
  class extraction_tracker;
    extract_result_t due_q[$];
    logic [7:0] target_chars [NAME_MAX];
    int unsigned target_len;
    bit too_long;
    phase_t phase;
    logic [31:0] pos;
    logic [31:0] name_size;
    logic [31:0] file_size;
    bit name_eq;
    bit trl_eq;
    bit selected;
    bit finished;
    int errors;
    int unsigned live_items;
    int unsigned results_due_total;

    function new();
      errors = 0;
      live_items = 0;
      results_due_total = 0;
      clear_state();
    endfunction

    function void clear_state();
      target_len = 0;
      too_long = 0;
      phase = PH_HEADER;
      pos = 0;
      name_size = 0;
      file_size = 0;
      name_eq = 1;
      trl_eq = 1;
      selected = 0;
      finished = 0;
    endfunction

    function void emit(input logic [1:0] st, input logic [7:0] d, input logic l);
      due_q.push_back('{status: st, data: d, last: l});
      results_due_total++;
    endfunction

    // Letters give c + 9 in the low nibble, anything else its own low nibble
    function logic [3:0] digit_value(input logic [7:0] c);
      if (c >= CHAR_A) begin
        return c[3:0] + 4'd9;
      end
      return c[3:0];
    endfunction

    function logic [31:0] name_pad_len();
      return (32'd4 - ((32'd110 + name_size) & 32'd3)) & 32'd3;
    endfunction

    function logic [31:0] data_pad_len();
      return (32'd4 - (file_size & 32'd3)) & 32'd3;
    endfunction

    function void go_header();
      phase = PH_HEADER;
      pos = 0;
    endfunction

    function void go_data_pad();
      if (data_pad_len() == 0) begin
        go_header();
      end else begin
        phase = PH_DATA_PAD;
        pos = 0;
      end
    endfunction

    function void go_data();
      if (file_size == 0) begin
        go_data_pad();
      end else begin
        phase = PH_DATA;
        pos = 0;
      end
    endfunction

    // Whole name seen: trailer wins over a target match
    function void decide_entry();
      bit trl;
      bit hit;
      trl = trl_eq && name_size > 32'd10;
      hit = name_eq && !too_long && name_size > target_len;
      if (trl) begin
        finished = 1;
        emit(ST_NOT_FOUND, 8'h00, 1'b1);
        return;
      end
      if (hit) begin
        selected = 1;
        if (file_size == 0) begin
          finished = 1;
          emit(ST_EMPTY, 8'h00, 1'b1);
          return;
        end
      end
      if (name_pad_len() == 0) begin
        go_data();
      end else begin
        phase = PH_NAME_PAD;
        pos = 0;
      end
    endfunction

    function void note_command(input logic [1:0] cmd, input logic [7:0] b);
      logic [31:0] i;
      bit at_end;
      i = pos;
      if (cmd != CMD_UNUSED && !(cmd == CMD_ARCHIVE && finished)) begin
        live_items++;
      end
      if (cmd == CMD_NAME_CHAR) begin
        if (b == CHAR_CR || b == CHAR_LF) begin
          return;
        end
        if (target_len < NAME_MAX) begin
          target_chars[target_len] = b;
          target_len++;
        end else begin
          too_long = 1;
        end
        return;
      end
      if (cmd == CMD_NEW_SEARCH) begin
        clear_state();
        return;
      end
      if (cmd != CMD_ARCHIVE || finished) begin
        return;
      end
      case (phase)
        PH_HEADER: begin
          if (i >= 32'd54 && i < 32'd62) begin
            file_size = {file_size[27:0], digit_value(b)};
          end
          if (i >= 32'd94 && i < 32'd102) begin
            name_size = {name_size[27:0], digit_value(b)};
          end
          if (i + 32'd1 >= HDR_BYTES) begin
            phase = PH_NAME;
            pos = 0;
            name_eq = 1;
            trl_eq = 1;
            if (name_size == 0) begin
              decide_entry();
            end
          end else begin
            pos = i + 32'd1;
          end
        end
        PH_NAME: begin
          if (i < target_len) begin
            if (target_chars[i] != b) begin
              name_eq = 0;
            end
          end else if (i == target_len) begin
            if (b != 8'h00) begin
              name_eq = 0;
            end
          end
          if (i < 32'd10) begin
            if (TRAILER_TEXT[79 - 8 * i -: 8] != b) begin
              trl_eq = 0;
            end
          end else if (i == 32'd10) begin
            if (b != 8'h00) begin
              trl_eq = 0;
            end
          end
          if (i + 32'd1 >= name_size) begin
            decide_entry();
          end else begin
            pos = i + 32'd1;
          end
        end
        PH_NAME_PAD: begin
          if (i + 32'd1 >= name_pad_len()) begin
            go_data();
          end else begin
            pos = i + 32'd1;
          end
        end
        PH_DATA: begin
          if (selected) begin
            at_end = (i + 32'd1 >= file_size);
            emit(ST_DATA, b, at_end);
            if (at_end) begin
              finished = 1;
            end else begin
              pos = i + 32'd1;
            end
          end else if (i + 32'd1 >= file_size) begin
            go_data_pad();
          end else begin
            pos = i + 32'd1;
          end
        end
        PH_DATA_PAD: begin
          if (i + 32'd1 >= data_pad_len()) begin
            go_header();
          end else begin
            pos = i + 32'd1;
          end
        end
        default: begin
          go_header();
        end
      endcase
    endfunction

    function void check_result(input logic [1:0] st, input logic [7:0] d, input logic l);
      extract_result_t want;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing due: expected none, actual %0d %02h %0b",
                 $time, st, d, l);
        return;
      end
      want = due_q.pop_front();
      if (want.status !== st) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, st);
      end
      if (want.data !== d) begin
        errors++;
        $display("%0t: data_out expected %02h actual %02h", $time, want.data, d);
      end
      if (want.last !== l) begin
        errors++;
        $display("%0t: last expected %0b actual %0b", $time, want.last, l);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  cpx_in_if  in_ch();
  cpx_out_if out_ch();

  cpio_newc_file_extractor_core #(
    .NAME_MAX(NAME_MAX)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  extraction_tracker tracker;

  // Generator side: the target as loaded, the name region of the entry being
  // built, and the archive bytes waiting to go out.
  logic [7:0] target_q[$];
  logic [7:0] name_region[$];
  logic [7:0] arch_q[$];

  int burst_left = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  bit long_hold_done = 1'b0;

  always #10 clk = ~clk;

  // Hard stop: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Sample both channels at the rising edge. Check the outgoing result first:
  // a result taken at this edge always belongs to an earlier command.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        tracker.check_result(out_ch.status, out_ch.data_out, out_ch.last);
        results_seen++;
      end
      if (in_ch.valid && in_ch.ready) begin
        tracker.note_command(in_ch.cmd, in_ch.data_byte);
      end
    end
  end

  // Result receiver: switch to a new random stall pattern after each random span.
  // Once, with a result waiting, hold off for a long stretch so the held
  // result backs up into the command channel while items keep being offered.
  initial begin
    int stall_mode;
    int span;
    int unsigned tick;
    out_ch.ready = 1'b0;
    tick = 0;
    forever begin
      stall_mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      repeat (span) begin
        @(negedge clk);
        tick++;
        if (!long_hold_done && results_seen >= 40 && out_ch.valid) begin
          out_ch.ready = 1'b0;
          repeat (LONG_HOLD - 1) @(negedge clk);
          long_hold_done = 1'b1;
        end
        case (stall_mode)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = $urandom_range(0, 1);
          2: out_ch.ready = ($urandom_range(0, 3) == 0);
          default: out_ch.ready = (tick % 3 != 0);
        endcase
      end
    end
  end

  // Offer one item and hold it until taken. Items come in bursts; a random
  // gap (possibly none) opens each new burst.
  task automatic drive_item(input logic [1:0] cmd, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.cmd = cmd;
    in_ch.data_byte = b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic new_search();
    drive_item(CMD_NEW_SEARCH, 8'($urandom_range(0, 255)));
    target_q.delete();
  endtask

  // Mirror what the block stores: CR and LF are dropped, overflow is not kept.
  task automatic load_char(input logic [7:0] c);
    drive_item(CMD_NAME_CHAR, c);
    if (c != CHAR_CR && c != CHAR_LF && target_q.size() < NAME_MAX) begin
      target_q.push_back(c);
    end
  endtask

  task automatic load_text(input string s);
    for (int k = 0; k < s.len(); k++) begin
      load_char(s[k]);
    end
  endtask

  // Mostly a small alphabet so that near misses are common.
  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 7) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return 8'h61 + 8'($urandom_range(0, 3));
  endfunction

  task automatic set_region_text(input string s, input bit nul);
    name_region.delete();
    for (int k = 0; k < s.len(); k++) begin
      name_region.push_back(s[k]);
    end
    if (nul) begin
      name_region.push_back(8'h00);
    end
  endtask

  task automatic add_hex(input logic [31:0] v, input bit lower);
    logic [3:0] nib;
    for (int k = 7; k >= 0; k--) begin
      nib = v[4 * k +: 4];
      if (nib < 4'd10) begin
        arch_q.push_back(8'h30 + nib);
      end else begin
        arch_q.push_back((lower ? 8'h61 : 8'h41) + nib - 8'd10);
      end
    end
  endtask

  // Append one entry: header, the current name region, padding, data.
  // A garbled entry gets a random byte in place of a low size digit.
  task automatic add_entry(input logic [31:0] fsize, input bit garble);
    bit lower;
    int npad;
    int dpad;
    lower = $urandom_range(0, 1);
    for (int k = 0; k < 6; k++) begin
      arch_q.push_back(8'h30 + ((k == 3 || k == 5) ? 8'd1 : (k == 2 ? 8'd7 : 8'd0)));
    end
    repeat (48) arch_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
    add_hex(fsize, lower);
    repeat (32) arch_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
    add_hex(name_region.size(), lower);
    repeat (8) arch_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
    if (garble) begin
      arch_q[arch_q.size() - ($urandom_range(0, 1) ? 9 : 49)] = 8'($urandom_range(0, 255));
    end
    foreach (name_region[k]) begin
      arch_q.push_back(name_region[k]);
    end
    npad = (4 - ((HDR_BYTES + name_region.size()) % 4)) % 4;
    repeat (npad) arch_q.push_back(8'($urandom_range(0, 255)));
    repeat (fsize) arch_q.push_back(8'($urandom_range(0, 255)));
    dpad = (4 - (fsize % 4)) % 4;
    repeat (dpad) arch_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_trailer();
    set_region_text("TRAILER!!!", 1'b1);
    add_entry(0, 1'b0);
  endtask

  // Send the built archive; optionally cut it short or slip in a name
  // character in front of a given byte.
  task automatic flush_archive(input int stop_at, input int inject_at,
                               input logic [7:0] inject_char);
    for (int k = 0; k < arch_q.size() && k != stop_at; k++) begin
      if (k == inject_at) begin
        load_char(inject_char);
      end
      drive_item(CMD_ARCHIVE, arch_q[k]);
    end
    arch_q.delete();
  endtask

  // One random search: mostly well-formed archives whose entries are exact
  // matches, near misses, nameless or trailer-like; sometimes plain noise,
  // a truncated archive, a stray name character or an unused command.
  task automatic random_archive();
    int tlen;
    int kind;
    int flip;
    int stop_at;
    int inject_at;
    logic [31:0] fsize;
    if ($urandom_range(0, 19) != 0) begin
      new_search();
    end
    tlen = ($urandom_range(0, 14) == 0) ? $urandom_range(250, 262) : $urandom_range(0, 8);
    repeat (tlen) begin
      if ($urandom_range(0, 19) == 0) begin
        load_char($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
      end else begin
        load_char(pick_char());
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(20, 200)) arch_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        kind = $urandom_range(0, 9);
        name_region.delete();
        foreach (target_q[k]) begin
          name_region.push_back(target_q[k]);
        end
        case (kind)
          0, 1, 2: begin
            name_region.push_back(8'h00);
            if ($urandom_range(0, 3) == 0) begin
              repeat ($urandom_range(1, 5)) name_region.push_back(pick_char());
            end
          end
          3: begin
            if (name_region.size() > 0) begin
              void'(name_region.pop_back());
            end
            name_region.push_back(8'h00);
          end
          4: begin
            name_region.push_back(pick_char());
            name_region.push_back(8'h00);
          end
          5: begin
            if (name_region.size() > 0) begin
              flip = $urandom_range(0, name_region.size() - 1);
              name_region[flip] = name_region[flip] ^ (8'h01 << $urandom_range(0, 7));
            end
            name_region.push_back(8'h00);
          end
          6: begin
            // name without its terminating zero
          end
          7: begin
            name_region.delete();
            repeat ($urandom_range(1, 6)) name_region.push_back(pick_char());
            name_region.push_back(8'h00);
          end
          8: begin
            name_region.delete();
          end
          default: begin
            if ($urandom_range(0, 1)) begin
              set_region_text("TRAILER!!", $urandom_range(0, 1));
            end else begin
              set_region_text("TRAILER!!!", $urandom_range(0, 1));
            end
          end
        endcase
        if ($urandom_range(0, 5) == 0) begin
          fsize = 0;
        end else if ($urandom_range(0, 7) == 0) begin
          fsize = $urandom_range(13, 60);
        end else begin
          fsize = $urandom_range(1, 12);
        end
        add_entry(fsize, $urandom_range(0, 49) == 0);
      end
      if ($urandom_range(0, 9) != 0) begin
        add_trailer();
      end
    end
    stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, arch_q.size() - 1) : -1;
    inject_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, arch_q.size() - 1) : -1;
    if ($urandom_range(0, 7) == 0) begin
      drive_item(CMD_UNUSED, 8'($urandom_range(0, 255)));
    end
    flush_archive(stop_at, inject_at, pick_char());
  endtask

  initial begin
    tracker = new();
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_NAME_CHAR;
    in_ch.data_byte = 8'h00;
    rst = 1'b1;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Straight out of reset the target is empty: a name that is a lone zero
    // matches. The trailer after it must be dropped.
    set_region_text("", 1'b1);
    add_entry(2, 1'b0);
    add_trailer();
    flush_archive(-1, -1, 8'h00);

    // Ordinary hit after a miss, a shorter and a longer near miss; then an
    // archive byte past the end and an unused command, both without result.
    new_search();
    load_text("a.txt");
    set_region_text("b", 1'b1);
    add_entry(3, 1'b0);
    set_region_text("a.tx", 1'b1);
    add_entry(1, 1'b0);
    set_region_text("a.txtx", 1'b1);
    add_entry(2, 1'b0);
    set_region_text("a.txt", 1'b1);
    add_entry(5, 1'b0);
    add_trailer();
    flush_archive(-1, -1, 8'h00);
    drive_item(CMD_ARCHIVE, 8'hFF);
    drive_item(CMD_UNUSED, 8'h5A);

    // CR and LF in the target are dropped; the match is an empty file.
    new_search();
    load_text("x\r\ny");
    set_region_text("xy", 1'b1);
    add_entry(0, 1'b0);
    flush_archive(-1, -1, 8'h00);

    // Empty name, then the target without its zero; end on the trailer.
    new_search();
    load_text("q");
    name_region.delete();
    add_entry(3, 1'b0);
    set_region_text("q", 1'b0);
    add_entry(1, 1'b0);
    add_trailer();
    flush_archive(-1, -1, 8'h00);

    // A target spelled like the trailer: the trailer check comes first.
    new_search();
    load_text("TRAILER!!!");
    set_region_text("TRAILER!!", 1'b1);
    add_entry(1, 1'b0);
    add_trailer();
    flush_archive(-1, -1, 8'h00);

    // Overflowed target never matches, even against its first NAME_MAX chars.
    new_search();
    repeat (NAME_MAX + 1) load_char("k");
    name_region.delete();
    repeat (NAME_MAX) name_region.push_back("k");
    name_region.push_back(8'h00);
    add_entry(4, 1'b0);
    add_trailer();
    flush_archive(-1, -1, 8'h00);

    // Target filling the store exactly still matches.
    new_search();
    repeat (NAME_MAX) load_char("m");
    name_region.delete();
    repeat (NAME_MAX) name_region.push_back("m");
    name_region.push_back(8'h00);
    add_entry(26, 1'b0);
    flush_archive(-1, -1, 8'h00);

    // Extend the target while the entry name is streaming in.
    new_search();
    load_text("ab");
    set_region_text("abc", 1'b1);
    add_entry(4, 1'b0);
    add_trailer();
    flush_archive(-1, HDR_BYTES + 1, "c");

    while (tracker.live_items < 2000 || tracker.results_due_total < 60) begin
      random_archive();
    end

    @(negedge clk);
    in_ch.valid = 1'b0;

    // Drain, then keep clocking so the output register can still misbehave.
    while (tracker.due_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (tracker.errors == 0 && tracker.due_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### cpio_newc_file_extractor_core.f
hdl/cpx_pkg.sv
hdl/cpx_if.sv
hdl/cpx_ram.sv
hdl/cpio_newc_file_extractor_core.sv
hdl/cpx_checker.sv
sim/testbench.sv
